// ===== design/mmm_pkg.sv =====
// Shared types, constants and helpers for the Montgomery multiplier.
package mmm_pkg;

  localparam int MaxWords = 8;
  localparam int WordW    = 32;
  localparam int OpW      = MaxWords * WordW;
  localparam int AccWords = MaxWords + 2;
  localparam int AccW     = AccWords * WordW;
  localparam int CntW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgW     = 64;

  localparam logic [CfgIdxW-1:0] RegMod0      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMod1      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMod2      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMod3      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNegInv    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWordCount = 3'd5;

  typedef struct packed {
    logic [63:0] y_w3;
    logic [63:0] y_w2;
    logic [63:0] y_w1;
    logic [63:0] y_w0;
    logic [63:0] x_w3;
    logic [63:0] x_w2;
    logic [63:0] x_w1;
    logic [63:0] x_w0;
  } in_t;

  typedef struct packed {
    logic [3:0]  sig_words;
    logic [63:0] prod_w3;
    logic [63:0] prod_w2;
    logic [63:0] prod_w1;
    logic [63:0] prod_w0;
  } out_t;

  // operands and accumulator travelling down the pipe
  typedef struct packed {
    logic [OpW-1:0]  x;
    logic [OpW-1:0]  y;
    logic [AccW-1:0] c;
  } work_t;

  function automatic logic [CntW-1:0] eff_words(input logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = n;
    if (n == '0) r = CntW'(1);
    if (n > CntW'(MaxWords)) r = CntW'(MaxWords);
    return r;
  endfunction

  function automatic logic [AccW-1:0] word_mask(input logic [CntW-1:0] n);
    logic [AccW-1:0] m;
    for (int k = 0; k < AccWords; k++) begin
      m[k*WordW +: WordW] = (k < int'(n)) ? '1 : '0;
    end
    return m;
  endfunction

endpackage

// ===== design/mmm_iter.sv =====
// One outer digit step of the Montgomery product, four register stages.
module mmm_iter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [2:0]                    digit,
  input  logic [3:0]                    words,
  input  logic [255:0]                  modulus,
  input  logic [31:0]                   neg_inv,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mmm_pkg::work_t                in_work,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mmm_pkg::work_t                out_work
);
  import mmm_pkg::*;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  work_t w1, w2, w3, w4;
  logic [63:0] p1 [MaxWords];
  logic [63:0] q3 [MaxWords];
  logic [63:0] prod [MaxWords];
  logic [63:0] qprod [MaxWords];
  logic [AccW-1:0] t2, t3;
  logic [31:0] ui2;
  logic [WordW-1:0] yi;
  logic [WordW-1:0] s_lo;
  logic [63:0] ui_full;
  logic [AccW-1:0] add2, add4, shifted;
  logic skip;

  assign r4 = !v4 || !out_stall;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;
  assign out_valid = v4;
  assign out_work = w4;

  assign skip = ({1'b0, digit} >= words);
  assign yi = in_work.y[{digit, 5'b0} +: WordW];

  always_comb begin
    for (int j = 0; j < MaxWords; j++) begin
      prod[j]  = {32'b0, in_work.x[j*WordW +: WordW]} * {32'b0, yi};
      qprod[j] = {32'b0, modulus[j*WordW +: WordW]} * {32'b0, ui2};
    end
  end

  // x*y_i folded into the accumulator: even products line up, odd ones sit a word up
  assign add2 = w1.c + {64'b0, p1[6], p1[4], p1[2], p1[0]}
              + {32'b0, p1[7], p1[5], p1[3], p1[1], 32'b0};
  assign s_lo = p1[0][31:0] + w1.c[31:0];
  assign ui_full = {32'b0, s_lo} * {32'b0, neg_inv};

  assign add4 = (t3 + {64'b0, q3[6], q3[4], q3[2], q3[0]}
              + {32'b0, q3[7], q3[5], q3[3], q3[1], 32'b0})
              & word_mask(4'(words + 4'd2));
  assign shifted = add4 >> WordW;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      w1 <= in_work;
      for (int j = 0; j < MaxWords; j++) p1[j] <= prod[j];
    end
    if (r2) begin
      w2 <= w1;
      t2 <= add2 & word_mask(4'(words + 4'd2));
      ui2 <= ui_full[31:0];
    end
    if (r3) begin
      w3 <= w2;
      t3 <= t2;
      for (int j = 0; j < MaxWords; j++) q3[j] <= qprod[j];
    end
    if (r4) begin
      w4.x <= w3.x;
      w4.y <= w3.y;
      w4.c <= skip ? w3.c : shifted;
    end
  end

endmodule

// ===== design/mmm_final.sv =====
// Final conditional subtraction, word count and output register.
module mmm_final (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     words,
  input  logic [255:0]   modulus,
  input  logic           in_valid,
  output logic           in_stall,
  input  mmm_pkg::work_t in_work,
  output logic           out_valid,
  input  logic           out_stall,
  output mmm_pkg::out_t  out_data
);
  import mmm_pkg::*;

  logic v1, v2, r1, r2;
  logic [AccW:0] diff;
  logic ge;
  logic [OpW-1:0] res, res1;
  logic [AccW-1:0] wmask;
  logic [3:0] sig;
  out_t out_reg;

  assign r2 = !v2 || !out_stall;
  assign r1 = !v1 || r2;
  assign in_stall = !r1;
  assign out_valid = v2;
  assign out_data = out_reg;

  // no borrow means accumulator >= modulus
  assign diff = {1'b0, in_work.c} - {65'b0, modulus};
  assign ge = !diff[AccW];
  assign wmask = word_mask(words);
  assign res = (ge ? diff[OpW-1:0] : in_work.c[OpW-1:0]) & wmask[OpW-1:0];

  always_comb begin
    sig = '0;
    for (int k = 0; k < MaxWords; k++) begin
      if (res1[k*WordW +: WordW] != '0) sig = 4'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) res1 <= res;
    if (r2) begin
      out_reg.prod_w0   <= res1[63:0];
      out_reg.prod_w1   <= res1[127:64];
      out_reg.prod_w2   <= res1[191:128];
      out_reg.prod_w3   <= res1[255:192];
      out_reg.sig_words <= sig;
    end
  end

endmodule

// ===== design/montgomery_mod_mul_256_unit.sv =====
// Montgomery multiplier top level: x*y*R^-1 mod m, R = 2^(32*word_count), 32-bit digits.
// A fully pipelined unit: one request is taken every cycle while the input is not stalled,
// and its result passes through four stages for each of the eight digit steps and two for
// the final subtraction and word count; each digit step's multiplier banks set that depth.
// Stages hold their data on stall and bubbles close up, so the input is stalled only
// when every stage is full and the result is not being taken. Configuration must be written
// only while no request is in flight; the block itself does not enforce this.
module montgomery_mod_mul_256_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [63:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mmm_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mmm_pkg::out_t               out_data
);
  import mmm_pkg::*;

  logic [OpW-1:0] modulus;
  logic [31:0] neg_inv;
  logic [3:0] word_count;
  logic [3:0] words;
  logic [AccW-1:0] wmask;
  logic [OpW-1:0] m_masked;

  logic  st_valid [MaxWords+1];
  logic  st_stall [MaxWords+1];
  work_t st_work  [MaxWords+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= '0;
      neg_inv    <= '0;
      word_count <= 4'(MaxWords);
    end else if (cfg_we) begin
      case (cfg_index)
        RegMod0:      modulus[63:0]    <= cfg_data;
        RegMod1:      modulus[127:64]  <= cfg_data;
        RegMod2:      modulus[191:128] <= cfg_data;
        RegMod3:      modulus[255:192] <= cfg_data;
        RegNegInv:    neg_inv          <= cfg_data[31:0];
        RegWordCount: word_count       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign words = eff_words(word_count);
  assign wmask = word_mask(words);
  assign m_masked = modulus & wmask[OpW-1:0];

  assign st_valid[0] = in_valid;
  assign in_stall = st_stall[0];
  assign st_work[0] = {
    {in_data.x_w3, in_data.x_w2, in_data.x_w1, in_data.x_w0} & wmask[OpW-1:0],
    {in_data.y_w3, in_data.y_w2, in_data.y_w1, in_data.y_w0} & wmask[OpW-1:0],
    {AccW{1'b0}}};

  for (genvar g = 0; g < MaxWords; g++) begin : g_step
    mmm_iter u_iter (
      .clk      (clk),
      .rst      (rst),
      .digit    (3'(g)),
      .words    (words),
      .modulus  (m_masked),
      .neg_inv  (neg_inv),
      .in_valid (st_valid[g]),
      .in_stall (st_stall[g]),
      .in_work  (st_work[g]),
      .out_valid(st_valid[g+1]),
      .out_stall(st_stall[g+1]),
      .out_work (st_work[g+1])
    );
  end

  mmm_final u_final (
    .clk      (clk),
    .rst      (rst),
    .words    (words),
    .modulus  (m_masked),
    .in_valid (st_valid[MaxWords]),
    .in_stall (st_stall[MaxWords]),
    .in_work  (st_work[MaxWords]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // the input only backs up when the whole pipe is full behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipe");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");

  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sig_words <= words))
    else $error("significant word count beyond active words");

  a_sig_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sig_words == 4'd0) |->
      (out_data.prod_w0 == '0 && out_data.prod_w1 == '0 &&
       out_data.prod_w2 == '0 && out_data.prod_w3 == '0))
    else $error("zero word count with nonzero product");

endmodule
